// ----- rtl/jsu_pkg.sv -----
// Package: shared types, constants and helper functions for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int LIMIT_W = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;
    localparam int MAX_RES = 5;
    localparam int RES_IDX_W = $clog2(MAX_RES + 1);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_STR   = 3'd1,
        PH_ESC   = 3'd2,
        PH_HEXH  = 3'd3,
        PH_HEXL  = 3'd4,
        PH_HWAIT = 3'd5,
        PH_HBSL  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_EXP_STR   = 3'd1,
        ERR_TRUNC_U   = 3'd2,
        ERR_INV_U     = 3'd3,
        ERR_TRUNC_SUR = 3'd4,
        ERR_INV_SUR   = 3'd5,
        ERR_BAD_ESC   = 3'd6,
        ERR_UNTERM    = 3'd7
    } err_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       done_res;
        err_t       error_code;
    } res_t;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
    } utf8_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] val;
    } hex_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] HI_FIRST = 16'hD800;
    localparam logic [15:0] HI_LAST  = 16'hDBFF;
    localparam logic [15:0] LO_FIRST = 16'hDC00;
    localparam logic [15:0] LO_LAST  = 16'hDFFF;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.len      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.len      = 3'd2;
            r.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
            r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.len      = 3'd3;
            r.bytes[0] = 8'hE0 | {4'h0, cp[15:12]};
            r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
        end else begin
            r.len      = 3'd4;
            r.bytes[0] = 8'hF0 | {5'h00, cp[20:18]};
            r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
            r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
        end
        return r;
    endfunction

    function automatic hex_t hex_nibble(input logic [7:0] b);
        hex_t r;
        r.bad = 1'b0;
        r.val = 4'h0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r.val = 4'(b - 8'h37);
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/jsu_if.sv -----
// Interfaces: text byte channel and decoded result channel.
`timescale 1ns / 1ps

interface jsu_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface jsu_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic [2:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output done_res,
                    output error_code, output last, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input done_res,
                  input error_code, input last, output ready);
endinterface

// ----- rtl/json_string_unescape.sv -----
// Top level: JSON string unescaper with UTF-8 output.
//
//  channel   dir  payload                                          handshake
//  text      in   in_byte[7:0]                                     valid/ready
//  decoded   out  out_byte, byte_valid, done_res, error_code, last valid/ready
//  cfg       in   cfg_wdata[15:0] (out_limit)                      cfg_we
//
// A text byte is decoded in the cycle it is accepted; its results (0 to 4) land
// in a small result buffer and leave one per cycle, while output stalls hold
// the buffer. A byte giving N results holds the text channel until its last
// result is taken; plain bytes go one per cycle. Reset: idle, out_limit 256.
`timescale 1ns / 1ps

module json_string_unescape #(
    parameter int COUNT_BITS = jsu_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    jsu_text_if.sink                    text,
    jsu_res_if.source                   decoded,
    input  logic                        cfg_we,
    input  logic [jsu_pkg::LIMIT_W-1:0] cfg_wdata
);

    localparam int CMP_W = ((COUNT_BITS > jsu_pkg::LIMIT_W) ? COUNT_BITS : jsu_pkg::LIMIT_W) + 1;

    logic [jsu_pkg::LIMIT_W-1:0]   limit_reg;
    jsu_pkg::phase_t               phase_reg, phase_next;
    logic [15:0]                   accum_reg, accum_next;
    logic [1:0]                    count_reg, count_next;
    logic                          bad_reg, bad_next;
    logic [15:0]                   hh_reg, hh_next;
    logic [COUNT_BITS-1:0]         bw_reg, bw_next;
    jsu_pkg::res_t                 buf_reg [jsu_pkg::MAX_RES];
    logic [jsu_pkg::RES_IDX_W-1:0] n_reg, n_next;
    logic [jsu_pkg::RES_IDX_W-1:0] idx_reg, idx_next;

    logic                          in_fire, out_fire, out_last;
    logic [7:0]                    b;
    logic                          lim_base, lim_mid, str_lim;
    logic [COUNT_BITS-1:0]         bw_mid;
    jsu_pkg::hex_t                 hd;
    logic [15:0]                   acc_new;
    logic [20:0]                   pair_cp;
    jsu_pkg::utf8_t                enc;

    // per-character decode results
    logic                          str_tail_vld, esc_tail_vld;
    jsu_pkg::res_t                 str_tail, esc_tail;
    jsu_pkg::phase_t               str_phase, esc_phase;

    // collected item results: code point bytes then one tail
    logic [20:0]                   cp_val;
    logic                          cp_put;
    logic                          tail_vld;
    jsu_pkg::res_t                 tail;
    logic                          bw_clear;
    logic [2:0]                    cp_len;
    jsu_pkg::res_t                 res_new [jsu_pkg::MAX_RES];

    assign b        = text.in_byte;
    assign out_last = (idx_reg + 1'b1) == n_reg;
    assign out_fire = decoded.valid && decoded.ready;
    assign in_fire  = text.valid && text.ready;

    assign text.ready         = (idx_reg == n_reg) || (out_last && decoded.ready);
    assign decoded.valid      = idx_reg != n_reg;
    assign decoded.out_byte   = buf_reg[idx_reg].out_byte;
    assign decoded.byte_valid = buf_reg[idx_reg].byte_valid;
    assign decoded.done_res   = buf_reg[idx_reg].done_res;
    assign decoded.error_code = buf_reg[idx_reg].error_code;
    assign decoded.last       = out_last;

    assign bw_mid   = bw_reg + COUNT_BITS'(3);
    assign lim_base = (CMP_W'(bw_reg) + CMP_W'(4)) >= CMP_W'(limit_reg);
    assign lim_mid  = (CMP_W'(bw_mid) + CMP_W'(4)) >= CMP_W'(limit_reg);
    assign str_lim  = (phase_reg == jsu_pkg::PH_HWAIT) ? lim_mid : lim_base;

    assign hd      = jsu_pkg::hex_nibble(b);
    assign acc_new = {accum_reg[11:0], hd.val};
    assign pair_cp = 21'h10000 + {1'b0, hh_reg[9:0], acc_new[9:0]};
    assign enc     = jsu_pkg::utf8_encode(cp_val);
    assign cp_len  = cp_put ? enc.len : 3'd0;

    // plain string character
    always_comb
    begin
        str_tail_vld = 1'b1;
        str_tail     = '0;
        str_phase    = jsu_pkg::PH_IDLE;
        if (str_lim) begin
            if (b == jsu_pkg::CH_QUOTE) begin
                str_tail.done_res = 1'b1;
            end else begin
                str_tail.error_code = jsu_pkg::ERR_UNTERM;
            end
        end else if (b == 8'h00) begin
            str_tail.error_code = jsu_pkg::ERR_UNTERM;
        end else if (b == jsu_pkg::CH_QUOTE) begin
            str_tail.done_res = 1'b1;
        end else if (b == jsu_pkg::CH_BSL) begin
            str_tail_vld = 1'b0;
            str_phase    = jsu_pkg::PH_ESC;
        end else begin
            str_tail.out_byte   = b;
            str_tail.byte_valid = 1'b1;
            str_phase           = jsu_pkg::PH_STR;
        end
    end

    // character after a backslash
    always_comb
    begin
        esc_tail_vld        = 1'b1;
        esc_tail            = '0;
        esc_tail.byte_valid = 1'b1;
        esc_phase           = jsu_pkg::PH_STR;
        case (b)
            jsu_pkg::CH_QUOTE: esc_tail.out_byte = jsu_pkg::CH_QUOTE;
            jsu_pkg::CH_BSL:   esc_tail.out_byte = jsu_pkg::CH_BSL;
            jsu_pkg::CH_SLASH: esc_tail.out_byte = jsu_pkg::CH_SLASH;
            8'h62:             esc_tail.out_byte = 8'h08;
            8'h66:             esc_tail.out_byte = 8'h0C;
            8'h6E:             esc_tail.out_byte = 8'h0A;
            8'h72:             esc_tail.out_byte = 8'h0D;
            8'h74:             esc_tail.out_byte = 8'h09;
            jsu_pkg::CH_U:
            begin
                esc_tail_vld        = 1'b0;
                esc_tail.byte_valid = 1'b0;
                esc_phase           = jsu_pkg::PH_HEXH;
            end
            default:
            begin
                esc_tail.byte_valid = 1'b0;
                esc_tail.error_code = jsu_pkg::ERR_BAD_ESC;
                esc_phase           = jsu_pkg::PH_IDLE;
            end
        endcase
    end

    // next state for one accepted text byte
    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        bad_next   = bad_reg;
        hh_next    = hh_reg;
        cp_val     = '0;
        cp_put     = 1'b0;
        tail_vld   = 1'b0;
        tail       = '0;
        bw_clear   = 1'b0;
        case (phase_reg)
            jsu_pkg::PH_STR:
            begin
                tail_vld   = str_tail_vld;
                tail       = str_tail;
                phase_next = str_phase;
            end
            jsu_pkg::PH_ESC:
            begin
                tail_vld   = esc_tail_vld;
                tail       = esc_tail;
                phase_next = esc_phase;
                if (b == jsu_pkg::CH_U) begin
                    accum_next = '0;
                    count_next = '0;
                    bad_next   = 1'b0;
                end
            end
            jsu_pkg::PH_HEXH, jsu_pkg::PH_HEXL:
            begin
                if (b == 8'h00) begin
                    tail_vld        = 1'b1;
                    tail.error_code = (phase_reg == jsu_pkg::PH_HEXL) ?
                                      jsu_pkg::ERR_TRUNC_SUR : jsu_pkg::ERR_TRUNC_U;
                    phase_next      = jsu_pkg::PH_IDLE;
                end else begin
                    accum_next = acc_new;
                    bad_next   = bad_reg | hd.bad;
                    if (count_reg != 2'd3) begin
                        count_next = count_reg + 2'd1;
                    end else if (bad_reg | hd.bad) begin
                        tail_vld        = 1'b1;
                        tail.error_code = (phase_reg == jsu_pkg::PH_HEXL) ?
                                          jsu_pkg::ERR_INV_SUR : jsu_pkg::ERR_INV_U;
                        phase_next      = jsu_pkg::PH_IDLE;
                    end else if (phase_reg == jsu_pkg::PH_HEXH) begin
                        if (acc_new >= jsu_pkg::HI_FIRST && acc_new <= jsu_pkg::HI_LAST) begin
                            hh_next    = acc_new;
                            phase_next = jsu_pkg::PH_HWAIT;
                        end else begin
                            cp_val     = {5'h00, acc_new};
                            cp_put     = 1'b1;
                            phase_next = jsu_pkg::PH_STR;
                        end
                    end else begin
                        if (acc_new >= jsu_pkg::LO_FIRST && acc_new <= jsu_pkg::LO_LAST) begin
                            cp_val = pair_cp;
                        end else begin
                            cp_val = {5'h00, hh_reg};
                        end
                        cp_put     = 1'b1;
                        phase_next = jsu_pkg::PH_STR;
                    end
                end
            end
            jsu_pkg::PH_HWAIT:
            begin
                if (b == jsu_pkg::CH_BSL) begin
                    phase_next = jsu_pkg::PH_HBSL;
                end else begin
                    cp_val     = {5'h00, hh_reg};
                    cp_put     = 1'b1;
                    tail_vld   = str_tail_vld;
                    tail       = str_tail;
                    phase_next = str_phase;
                end
            end
            jsu_pkg::PH_HBSL:
            begin
                if (b == jsu_pkg::CH_U) begin
                    accum_next = '0;
                    count_next = '0;
                    bad_next   = 1'b0;
                    phase_next = jsu_pkg::PH_HEXL;
                end else begin
                    cp_val = {5'h00, hh_reg};
                    cp_put = 1'b1;
                    if (lim_mid) begin
                        tail_vld        = 1'b1;
                        tail.error_code = jsu_pkg::ERR_UNTERM;
                        phase_next      = jsu_pkg::PH_IDLE;
                    end else begin
                        tail_vld   = esc_tail_vld;
                        tail       = esc_tail;
                        phase_next = esc_phase;
                    end
                end
            end
            default:
            begin
                phase_next = jsu_pkg::PH_IDLE;
                if (b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
                    phase_next = jsu_pkg::PH_IDLE;
                end else if (b == jsu_pkg::CH_QUOTE) begin
                    phase_next = jsu_pkg::PH_STR;
                    bw_clear   = 1'b1;
                end else begin
                    tail_vld        = 1'b1;
                    tail.error_code = jsu_pkg::ERR_EXP_STR;
                end
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
            res_new[i] = tail;
            if (i < 4 && 3'(i) < cp_len) begin
                res_new[i]            = '0;
                res_new[i].out_byte   = enc.bytes[i];
                res_new[i].byte_valid = 1'b1;
            end
        end
        n_next = jsu_pkg::RES_IDX_W'(cp_len) + jsu_pkg::RES_IDX_W'(tail_vld);
        if (bw_clear) begin
            bw_next = '0;
        end else begin
            bw_next = bw_reg + COUNT_BITS'(cp_len) + COUNT_BITS'(tail_vld & tail.byte_valid);
        end
        if (in_fire) begin
            idx_next = '0;
        end else if (out_fire) begin
            idx_next = idx_reg + 1'b1;
        end else begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_reg <= jsu_pkg::LIMIT_RESET;
            phase_reg <= jsu_pkg::PH_IDLE;
            accum_reg <= '0;
            count_reg <= '0;
            bad_reg   <= 1'b0;
            hh_reg    <= '0;
            bw_reg    <= '0;
            n_reg     <= '0;
            idx_reg   <= '0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            idx_reg <= idx_next;
            if (in_fire) begin
                phase_reg <= phase_next;
                accum_reg <= accum_next;
                count_reg <= count_next;
                bad_reg   <= bad_next;
                hh_reg    <= hh_next;
                bw_reg    <= bw_next;
                n_reg     <= n_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            for (int i = 0; i < jsu_pkg::MAX_RES; i++) begin
                buf_reg[i] <= res_new[i];
            end
        end
    end

endmodule
